[src/ckbfc_pkg.sv]
`timescale 1ns / 1ps

package ckbfc_pkg;

	localparam int SIZE_W  = 11;
	localparam int DEST_W  = 12;
	localparam int KEY_W   = 9;
	localparam int PIX_W   = 8;
	localparam int MODE_W  = 2;
	localparam int ADDR_W  = 20;
	localparam int COORD_W = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_X        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_Y        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_KEY     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_MODE   = 3'd7;

	localparam int MIRROR_H_BIT = 0;
	localparam int MIRROR_V_BIT = 1;

	typedef struct packed {
		logic [SIZE_W-1:0]        screen_width;
		logic [SIZE_W-1:0]        screen_height;
		logic signed [DEST_W-1:0] dest_x;
		logic signed [DEST_W-1:0] dest_y;
		logic [SIZE_W-1:0]        sprite_width;
		logic [SIZE_W-1:0]        sprite_height;
		logic signed [KEY_W-1:0]  color_key;
		logic [MODE_W-1:0]        mirror_mode;
	} cfg_t;

	typedef struct packed {
		logic               we;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PIX_W-1:0]   pix;
		logic               last;
	} entry_t;

endpackage

[src/ckbfc_front.sv]
`timescale 1ns / 1ps

module ckbfc_front #(
	parameter int MAX_SIDE = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ckbfc_pkg::cfg_t                  cfg,
	input  logic                             in_valid,
	input  logic [ckbfc_pkg::PIX_W-1:0]      pixel_in,
	input  logic                             queue_full,
	output logic                             push,
	output ckbfc_pkg::entry_t                entry,
	output logic [ckbfc_pkg::COORD_W-1:0]    fb_pitch
);

	localparam int CW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int XW = (SW > ckbfc_pkg::SIZE_W) ? SW : ckbfc_pkg::SIZE_W;
	localparam int DW = ((CW + 1 > ckbfc_pkg::DEST_W) ? CW + 1 : ckbfc_pkg::DEST_W) + 1;

	function automatic logic [SW-1:0] clamp_side(input logic [ckbfc_pkg::SIZE_W-1:0] v,
			input logic lo_one);
		logic [XW-1:0] ext;
		logic [XW-1:0] res;
		ext = XW'(v);
		if (lo_one && ext == '0) begin
			res = XW'(1);
		end else if (ext > XW'(MAX_SIDE)) begin
			res = XW'(MAX_SIDE);
		end else begin
			res = ext;
		end
		return SW'(res);
	endfunction

	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;

	logic [SW-1:0] sw;
	logic [SW-1:0] sh;
	logic [SW-1:0] fw;
	logic [SW-1:0] fh;
	logic [CW-1:0] last_c;
	logic [CW-1:0] last_r;
	logic [CW-1:0] c;
	logic [CW-1:0] r;
	logic [CW-1:0] mc;
	logic [CW-1:0] mr;
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic row_end;
	logic last;
	logic on_x;
	logic on_y;
	logic opaque;
	logic we;

	assign sw = clamp_side(cfg.sprite_width, 1'b1);
	assign sh = clamp_side(cfg.sprite_height, 1'b1);
	assign fw = clamp_side(cfg.screen_width, 1'b0);
	assign fh = clamp_side(cfg.screen_height, 1'b0);
	assign last_c = CW'(sw - SW'(1));
	assign last_r = CW'(sh - SW'(1));

	assign c = (col_q < last_c) ? col_q : last_c;
	assign r = (row_q < last_r) ? row_q : last_r;
	assign row_end = (c == last_c);
	assign last = row_end && (r == last_r);

	assign mc = cfg.mirror_mode[ckbfc_pkg::MIRROR_H_BIT] ? CW'(last_c - c) : c;
	assign mr = cfg.mirror_mode[ckbfc_pkg::MIRROR_V_BIT] ? CW'(last_r - r) : r;

	assign dx = DW'(cfg.dest_x) + DW'(mc);
	assign dy = DW'(cfg.dest_y) + DW'(mr);

	assign on_x = !dx[DW-1] && ($unsigned(dx) < DW'(fw));
	assign on_y = !dy[DW-1] && ($unsigned(dy) < DW'(fh));
	assign opaque = cfg.color_key[ckbfc_pkg::KEY_W-1]
		|| (pixel_in != cfg.color_key[ckbfc_pkg::PIX_W-1:0]);
	assign we = on_x && on_y && opaque;

	assign push = in_valid && !queue_full;

	assign entry.we   = we;
	assign entry.row  = we ? ckbfc_pkg::COORD_W'(dy) : '0;
	assign entry.col  = we ? ckbfc_pkg::COORD_W'(dx) : '0;
	assign entry.pix  = pixel_in;
	assign entry.last = last;

	assign fb_pitch = ckbfc_pkg::COORD_W'(fw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= CW'(r + 1'b1);
			end else begin
				col_q <= CW'(c + 1'b1);
				row_q <= r;
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && last |=> col_q == '0 && row_q == '0)
		else $error("counters not cleared after last word");

endmodule

[src/ckbfc_queue.sv]
`timescale 1ns / 1ps

module ckbfc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ckbfc_pkg::entry_t push_data,
	input  logic              pop,
	output ckbfc_pkg::entry_t pop_data,
	output logic              full,
	output logic              empty
);

	localparam int PW = $clog2(ckbfc_pkg::QUEUE_DEPTH);
	localparam int NW = $clog2(ckbfc_pkg::QUEUE_DEPTH + 1);

	ckbfc_pkg::entry_t slot_q [ckbfc_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] count_q;

	assign full  = (count_q == NW'(ckbfc_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= PW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= PW'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= NW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= NW'(count_q - 1'b1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(ckbfc_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

[src/ckbfc_back.sv]
`timescale 1ns / 1ps

module ckbfc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ckbfc_pkg::entry_t                 head,
	input  logic                              empty,
	input  logic [ckbfc_pkg::COORD_W-1:0]     fb_pitch,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              write_enable,
	output logic [ckbfc_pkg::ADDR_W-1:0]      fb_address,
	output logic [ckbfc_pkg::PIX_W-1:0]       pixel_out,
	output logic                              last_pixel
);

	localparam int PRW = 2 * ckbfc_pkg::COORD_W;

	logic                            valid_s1;
	logic [PRW-1:0]                  prod_s1;
	logic [ckbfc_pkg::COORD_W-1:0]   col_s1;
	logic                            we_s1;
	logic [ckbfc_pkg::PIX_W-1:0]     pix_s1;
	logic                            last_s1;

	logic                            valid_s2;
	logic [ckbfc_pkg::ADDR_W-1:0]    addr_s2;
	logic                            we_s2;
	logic [ckbfc_pkg::PIX_W-1:0]     pix_s2;
	logic                            last_s2;

	logic take_s2;
	logic take_s1;

	assign take_s2 = !valid_s2 || !out_stall;
	assign take_s1 = !valid_s1 || take_s2;
	assign pop = take_s1 && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= pop;
			end
			if (take_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1 <= PRW'(head.row) * PRW'(fb_pitch);
			col_s1  <= head.col;
			we_s1   <= head.we;
			pix_s1  <= head.pix;
			last_s1 <= head.last;
		end
		if (take_s2 && valid_s1) begin
			addr_s2 <= ckbfc_pkg::ADDR_W'(prod_s1 + PRW'(col_s1));
			we_s2   <= we_s1;
			pix_s2  <= pix_s1;
			last_s2 <= last_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign write_enable = we_s2;
	assign fb_address   = addr_s2;
	assign pixel_out    = pix_s2;
	assign last_pixel   = last_s2;

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> fb_address == '0)
		else $error("nonzero address on dropped word");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take_s1 |=> valid_s1 && $stable(prod_s1))
		else $error("stage one lost under stall");

endmodule

[src/color_key_blit_flip_clip_core.sv]
`timescale 1ns / 1ps

// Color-key blitter with mirroring and clipping.
// Input channel: one source pixel word per accepted cycle (in_valid high,
// in_stall low), in source raster order. Output channel: one word per input
// word with write_enable, fb_address, pixel_out and last_pixel, taken when
// out_valid is high and out_stall is low. last_pixel marks the final pixel
// of the sprite; the column and row counters return to zero after it.
// Configuration: cfg_valid/cfg_ready write port, cfg_ready is always high.
// Index 0..7 selects screen_width, screen_height, dest_x, dest_y,
// sprite_width, sprite_height, color_key, mirror_mode. Write only while idle.
// Throughput: one word per cycle while out_stall is low. out_valid rises once
// the word has passed the queue write at the input accept, then the address
// multiply, then the address add.
// A four-entry queue parts the classifier from the address pipeline; when
// out_stall holds, the pipeline and then the queue fill and in_stall rises
// once the queue is full.
// Reset: counters clear, queue and pipeline empty, registers take 320, 240,
// 0, 0, 1, 1, -1 (key disabled) and 0.

module color_key_blit_flip_clip_core #(
	parameter int MAX_SIDE = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ckbfc_pkg::PIX_W-1:0]         pixel_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                write_enable,
	output logic [ckbfc_pkg::ADDR_W-1:0]        fb_address,
	output logic [ckbfc_pkg::PIX_W-1:0]         pixel_out,
	output logic                                last_pixel,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ckbfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ckbfc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	ckbfc_pkg::cfg_t   cfg_q;
	ckbfc_pkg::entry_t push_data;
	ckbfc_pkg::entry_t head;
	logic push;
	logic pop;
	logic full;
	logic empty;
	logic [ckbfc_pkg::COORD_W-1:0] fb_pitch;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= ckbfc_pkg::SIZE_W'(320);
			cfg_q.screen_height <= ckbfc_pkg::SIZE_W'(240);
			cfg_q.dest_x        <= '0;
			cfg_q.dest_y        <= '0;
			cfg_q.sprite_width  <= ckbfc_pkg::SIZE_W'(1);
			cfg_q.sprite_height <= ckbfc_pkg::SIZE_W'(1);
			cfg_q.color_key     <= '1;
			cfg_q.mirror_mode   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ckbfc_pkg::REG_SCREEN_WIDTH: begin
					cfg_q.screen_width <= cfg_data[ckbfc_pkg::SIZE_W-1:0];
				end
				ckbfc_pkg::REG_SCREEN_HEIGHT: begin
					cfg_q.screen_height <= cfg_data[ckbfc_pkg::SIZE_W-1:0];
				end
				ckbfc_pkg::REG_DEST_X: begin
					cfg_q.dest_x <= cfg_data[ckbfc_pkg::DEST_W-1:0];
				end
				ckbfc_pkg::REG_DEST_Y: begin
					cfg_q.dest_y <= cfg_data[ckbfc_pkg::DEST_W-1:0];
				end
				ckbfc_pkg::REG_SPRITE_WIDTH: begin
					cfg_q.sprite_width <= cfg_data[ckbfc_pkg::SIZE_W-1:0];
				end
				ckbfc_pkg::REG_SPRITE_HEIGHT: begin
					cfg_q.sprite_height <= cfg_data[ckbfc_pkg::SIZE_W-1:0];
				end
				ckbfc_pkg::REG_COLOR_KEY: begin
					cfg_q.color_key <= cfg_data[ckbfc_pkg::KEY_W-1:0];
				end
				ckbfc_pkg::REG_MIRROR_MODE: begin
					cfg_q.mirror_mode <= cfg_data[ckbfc_pkg::MODE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ckbfc_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.pixel_in  (pixel_in),
		.queue_full(full),
		.push      (push),
		.entry     (push_data),
		.fb_pitch  (fb_pitch)
	);

	ckbfc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (head),
		.full     (full),
		.empty    (empty)
	);

	ckbfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.fb_pitch    (fb_pitch),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.write_enable(write_enable),
		.fb_address  (fb_address),
		.pixel_out   (pixel_out),
		.last_pixel  (last_pixel)
	);

endmodule

[verif/blit_checker.sv]
`timescale 1ns / 1ps

module blit_checker
	import ckbfc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [PIX_W-1:0]      pixel_in,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  write_enable,
	input  logic [ADDR_W-1:0]     fb_address,
	input  logic [PIX_W-1:0]      pixel_out,
	input  logic                  last_pixel,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    in_flight
);

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  pix;
		logic              last;
	} fb_write_t;

	logic [SIZE_W-1:0]        scr_w, scr_h, spr_w, spr_h;
	logic signed [DEST_W-1:0] dst_x, dst_y;
	logic signed [KEY_W-1:0]  key;
	logic [MODE_W-1:0]        mode;
	logic [9:0]               col_cnt, row_cnt;

	fb_write_t pending_writes[$];

	function automatic int clamp_side(input logic [SIZE_W-1:0] v, input int lo);
		if (int'(v) < lo)
			return lo;
		if (int'(v) > 1024)
			return 1024;
		return int'(v);
	endfunction

	// advance the raster counters as a side effect
	function automatic fb_write_t blit_pixel(input logic [PIX_W-1:0] pix);
		int sw, sh, fw, fh, c, r, mc, mr, dx, dy;
		bit row_end, on_screen, opaque;
		fb_write_t w;
		sw = clamp_side(spr_w, 1);
		sh = clamp_side(spr_h, 1);
		fw = clamp_side(scr_w, 0);
		fh = clamp_side(scr_h, 0);
		c = (int'(col_cnt) < sw - 1) ? int'(col_cnt) : sw - 1;
		r = (int'(row_cnt) < sh - 1) ? int'(row_cnt) : sh - 1;
		row_end = (c == sw - 1);
		mc = mode[MIRROR_H_BIT] ? sw - 1 - c : c;
		mr = mode[MIRROR_V_BIT] ? sh - 1 - r : r;
		dx = int'(dst_x) + mc;
		dy = int'(dst_y) + mr;
		on_screen = dx >= 0 && dy >= 0 && dx < fw && dy < fh;
		opaque = (key < 0) || (pix != key[7:0]);
		w.we = on_screen && opaque;
		w.addr = w.we ? ADDR_W'(dy * fw + dx) : '0;
		w.pix = pix;
		w.last = row_end && (r == sh - 1);
		if (w.last) begin
			col_cnt = '0;
			row_cnt = '0;
		end else if (row_end) begin
			col_cnt = '0;
			row_cnt = 10'(r + 1);
		end else begin
			col_cnt = 10'(c + 1);
			row_cnt = 10'(r);
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fb_write_t got, want;
		if (!arst_n) begin
			scr_w = 11'd320;
			scr_h = 11'd240;
			dst_x = '0;
			dst_y = '0;
			spr_w = 11'd1;
			spr_h = 11'd1;
			key = -9'sd1;
			mode = '0;
			col_cnt = '0;
			row_cnt = '0;
			pending_writes.delete();
			mismatches <= 0;
			in_flight <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SCREEN_WIDTH:  scr_w = cfg_data[SIZE_W-1:0];
					REG_SCREEN_HEIGHT: scr_h = cfg_data[SIZE_W-1:0];
					REG_DEST_X:        dst_x = cfg_data[DEST_W-1:0];
					REG_DEST_Y:        dst_y = cfg_data[DEST_W-1:0];
					REG_SPRITE_WIDTH:  spr_w = cfg_data[SIZE_W-1:0];
					REG_SPRITE_HEIGHT: spr_h = cfg_data[SIZE_W-1:0];
					REG_COLOR_KEY:     key = cfg_data[KEY_W-1:0];
					REG_MIRROR_MODE:   mode = cfg_data[MODE_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got.we = write_enable;
				got.addr = fb_address;
				got.pix = pixel_out;
				got.last = last_pixel;
				if (pending_writes.size() == 0) begin
					$display("%0t: unexpected word we=%0b addr=%0d pix=%0d last=%0b",
						$time, got.we, got.addr, got.pix, got.last);
					mismatches <= mismatches + 1;
				end else begin
					want = pending_writes.pop_front();
					if (got.we !== want.we || got.addr !== want.addr ||
						got.pix !== want.pix || got.last !== want.last) begin
						$display({"%0t: mismatch, expected we=%0b addr=%0d pix=%0d last=%0b,",
							" got we=%0b addr=%0d pix=%0d last=%0b"}, $time,
							want.we, want.addr, want.pix, want.last,
							got.we, got.addr, got.pix, got.last);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				pending_writes.push_back(blit_pixel(pixel_in));
			in_flight <= pending_writes.size();
		end
	end

endmodule

[verif/tb_color_key_blit_flip_clip_core.sv]
`timescale 1ns / 1ps

module tb_color_key_blit_flip_clip_core;
	import ckbfc_pkg::*;

	localparam int PERIOD     = 8;
	localparam int LIMIT      = 1000000;
	localparam int WORD_COUNT = 1800;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [PIX_W-1:0]      pixel_in = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  write_enable;
	logic [ADDR_W-1:0]     fb_address;
	logic [PIX_W-1:0]      pixel_out;
	logic                  last_pixel;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SCREEN_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int          mismatches;
	int          in_flight;
	int unsigned cycle_count;
	bit          steady = 1'b0;
	bit          rx_long_req = 1'b0;

	always #(PERIOD / 2) clk = ~clk;

	color_key_blit_flip_clip_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_in(pixel_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.write_enable(write_enable),
		.fb_address(fb_address),
		.pixel_out(pixel_out),
		.last_pixel(last_pixel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	blit_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_in(pixel_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.write_enable(write_enable),
		.fb_address(fb_address),
		.pixel_out(pixel_out),
		.last_pixel(last_pixel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.in_flight(in_flight)
	);

	function automatic int word_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic int sprite_side(input logic [SIZE_W-1:0] v);
		if (v == 0)
			return 1;
		return (v > 1024) ? 1024 : int'(v);
	endfunction

	function automatic logic [SIZE_W-1:0] pick_screen();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return 11'd1;
			2: return 11'd1024;
			3: return 11'h7FF;
			default: return SIZE_W'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_sprite();
		case ($urandom_range(0, 29))
			0: return '0;
			1: return 11'h7FF;
			2: return 11'd1024;
			3: return 11'd1;
			default: return SIZE_W'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic logic [DEST_W-1:0] pick_dest(input int span);
		case ($urandom_range(0, 15))
			0: return 12'h800;
			1: return 12'h7FF;
			2: return DEST_W'($urandom);
			default: return DEST_W'(int'($urandom_range(0, span + 8)) - 8);
		endcase
	endfunction

	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// unused upper data bits carry noise
	task automatic program_blit(
		input logic [SIZE_W-1:0] scr_w, scr_h,
		input logic [DEST_W-1:0] dx, dy,
		input logic [SIZE_W-1:0] spr_w, spr_h,
		input logic [KEY_W-1:0]  key,
		input logic [MODE_W-1:0] mode
	);
		cfg_put(REG_SCREEN_WIDTH, {1'($urandom), scr_w});
		cfg_put(REG_SCREEN_HEIGHT, {1'($urandom), scr_h});
		cfg_put(REG_DEST_X, dx);
		cfg_put(REG_DEST_Y, dy);
		cfg_put(REG_SPRITE_WIDTH, {1'($urandom), spr_w});
		cfg_put(REG_SPRITE_HEIGHT, {1'($urandom), spr_h});
		cfg_put(REG_COLOR_KEY, {3'($urandom), key});
		cfg_put(REG_MIRROR_MODE, {10'($urandom), mode});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_word(input logic [PIX_W-1:0] pix);
		int gap;
		gap = word_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= pix;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic stop_words();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drain();
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
	endtask

	// receiver: random stall runs, one long hold on request
	initial begin
		int run;
		int r;
		bit stall_val;
		bit long_taken;
		run = 0;
		stall_val = 1'b0;
		long_taken = 1'b0;
		@(posedge clk);
		forever begin
			if (rx_long_req && !long_taken) begin
				long_taken = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end else begin
				if (run == 0) begin
					r = $urandom_range(0, 99);
					if (r < 55) begin
						stall_val = 1'b0;
						run = $urandom_range(1, 12);
					end else if (r < 85) begin
						stall_val = 1'b1;
						run = $urandom_range(1, 3);
					end else if (r < 95) begin
						stall_val = 1'b0;
						run = $urandom_range(40, 150);
					end else begin
						stall_val = 1'b1;
						run = $urandom_range(15, 50);
					end
				end
				out_stall <= stall_val;
				run--;
				@(posedge clk);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [SIZE_W-1:0] scr_w, scr_h, spr_w, spr_h;
		logic [DEST_W-1:0] dx, dy;
		logic [KEY_W-1:0]  key;
		logic [PIX_W-1:0]  fill_pix;
		bit                fill;
		int                phase, words, area, n, span;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 1x1 sprite, every word is last
		send_word(8'h00);
		send_word(8'hFF);
		send_word(8'hA5);
		send_word(8'h5A);
		stop_words();
		wait_drain();

		// both mirrors, right edge clip, key 0
		program_blit(11'd4, 11'd3, 12'd2, 12'd1, 11'd3, 11'd2, 9'h000, 2'd3);
		for (int i = 0; i < 6; i++)
			send_word(i[0] ? 8'($urandom) : 8'h00);
		stop_words();
		wait_drain();

		// zero-width screen
		program_blit(11'd0, 11'd5, 12'd0, 12'd0, 11'd2, 11'd2, 9'h1FF, 2'd0);
		for (int i = 0; i < 4; i++)
			send_word(8'($urandom));
		stop_words();
		wait_drain();

		// oversize sprite and screen, zero height, far-off destination
		program_blit(11'h7FF, 11'h7FF, 12'h800, 12'h7FF, 11'h7FF, 11'd0, 9'h0FF, 2'd1);
		send_word(8'hFF);
		send_word(8'h00);
		send_word(8'h7F);
		stop_words();
		wait_drain();

		// shrink width mid-row, bottom-right corner of the largest screen
		program_blit(11'd1024, 11'd1024, 12'd1023, 12'd1023, 11'd2, 11'd1, 9'h100, 2'd3);
		for (int i = 0; i < 5; i++)
			send_word(i[0] ? 8'h00 : 8'($urandom));
		stop_words();
		wait_drain();

		phase = 0;
		words = 0;
		while (words < WORD_COUNT) begin
			phase++;
			fill = ($urandom_range(0, 7) == 0);
			fill_pix = 8'($urandom);
			scr_w = pick_screen();
			scr_h = pick_screen();
			span = (scr_w > 1024) ? 1024 : int'(scr_w);
			dx = pick_dest(span);
			span = (scr_h > 1024) ? 1024 : int'(scr_h);
			dy = pick_dest(span);
			spr_w = pick_sprite();
			spr_h = pick_sprite();
			case ($urandom_range(0, 3))
				0: key = 9'h1FF;
				1: key = {1'b1, 8'($urandom)};
				default: key = {1'b0, 8'($urandom)};
			endcase
			if (fill)
				key = 9'h1FF;
			program_blit(scr_w, scr_h, dx, dy, spr_w, spr_h, key, 2'($urandom));
			area = sprite_side(spr_w) * sprite_side(spr_h);
			if (area <= 36) begin
				n = area * $urandom_range(1, 4);
				if ($urandom_range(0, 4) == 0)
					n += $urandom_range(1, 3);
			end else begin
				n = $urandom_range(1, 60);
			end
			steady = ($urandom_range(0, 3) == 0);
			if (phase == 6) begin
				rx_long_req <= 1'b1;
				steady = 1'b1;
				if (n < 40)
					n = 40;
			end
			for (int i = 0; i < n; i++) begin
				if (fill)
					send_word(fill_pix);
				else if (!key[KEY_W-1] && $urandom_range(0, 3) == 0)
					send_word(key[PIX_W-1:0]);
				else
					send_word(8'($urandom));
				words++;
			end
			stop_words();
			wait_drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
